// ===== rtl/hst_pkg.sv =====
// ----------------------------------------------------------------------------
// hst_pkg
// shared types and constants for the handle slot table
// ----------------------------------------------------------------------------
package hst_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int GROUP_SIZE     = 16;
    localparam int REF_W          = 64;
    localparam int SLOT_W         = 8;
    localparam int REQ_W          = 2;

    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } st_t;

endpackage

// ===== rtl/handle_slot_table.sv =====
// ----------------------------------------------------------------------------
// handle_slot_table
// per-thread object reference table with lowest-free-slot allocation
// ----------------------------------------------------------------------------
// Usage:
// A request transaction (req_type, slot_index, object_ref) enters on the
// in_valid/in_stall channel; each request yields exactly one result
// transaction (ok, slot_out, object_out) on the out_valid/out_stall channel.
// References live in a one-port synchronous RAM of SLOT_COUNT x 64 bits;
// a flop bitmap marks occupied slots, and adding a zero reference occupies no slot.
// Timing: the accept cycle reads the RAM and registers per-group lowest-free
// encodes over 16-slot groups; the execute cycle picks the first group,
// writes the RAM and bitmap and loads the output register. out_valid rises
// as the output register is loaded; a new request is not accepted until
// the previous one has executed, as in_stall stays high in the execute state.
// While a result is held by out_stall the next request may still be
// accepted, but its execute cycle waits until the output register empties.
// Reset empties the bitmap at once, so all slots read as free; RAM contents
// need no clearing.
// ----------------------------------------------------------------------------
module handle_slot_table
    import hst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [SLOT_W-1:0] slot_index,
    input  logic [REF_W-1:0]  object_ref,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [SLOT_W-1:0] slot_out,
    output logic [REF_W-1:0]  object_out
);

    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int GROUPS  = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD     = GROUPS * GROUP_SIZE;
    localparam int PAD_W   = $clog2(PAD);
    localparam int GROUP_W = $clog2(GROUP_SIZE);

    st_t state_reg, state_next;

    logic [SLOT_COUNT-1:0] occ_reg, occ_next;
    logic [REF_W-1:0]      mem [SLOT_COUNT];
    logic [REF_W-1:0]      rd_data_reg;

    logic [REQ_W-1:0]      req_reg;
    logic [SLOT_W-1:0]     hand_reg;
    logic [REF_W-1:0]      obj_reg;
    logic                  hand_occ_reg;
    logic [GROUPS-1:0]     grp_any_reg;
    logic [GROUP_W-1:0]    grp_low_reg [GROUPS];

    logic                  out_valid_reg;
    logic                  ok_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [REF_W-1:0]      obj_out_reg;

    logic                  in_fire;
    logic                  exec_fire;
    logic                  in_range;
    logic                  hand_occ;
    logic [PAD-1:0]        free_pad;
    logic [GROUPS-1:0]     grp_any;
    logic [GROUP_W-1:0]    grp_low [GROUPS];

    logic                  found;
    logic [PAD_W-1:0]      free_idx;
    logic                  res_ok;
    logic [SLOT_W-1:0]     res_slot;
    logic [REF_W-1:0]      res_obj;
    logic                  mem_we;
    logic                  occ_set;
    logic                  occ_clr;

    // control: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control: outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        in_fire   = in_valid && (state_reg == ST_IDLE);
        exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    end

    // accept stage: range check and grouped lowest-free encode
    always_comb
    begin
        in_range = ({1'b0, slot_index} < (SLOT_W + 1)'(SLOT_COUNT));
        hand_occ = in_range && occ_reg[slot_index[IDX_W-1:0]];
    end

    always_comb
    begin
        free_pad = '0;
        free_pad[SLOT_COUNT-1:0] = ~occ_reg;
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_any[g] = 1'b0;
            grp_low[g] = '0;
            for (int b = GROUP_SIZE - 1; b >= 0; b--)
            begin
                if (free_pad[g * GROUP_SIZE + b])
                begin
                    grp_any[g] = 1'b1;
                    grp_low[g] = GROUP_W'(b);
                end
            end
        end
    end

    // execute stage: first group with a free slot
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                found    = 1'b1;
                free_idx = (PAD_W'(g) << GROUP_W) | PAD_W'(grp_low_reg[g]);
            end
        end
    end

    always_comb
    begin
        res_ok   = 1'b0;
        res_slot = '0;
        res_obj  = '0;
        mem_we   = 1'b0;
        occ_set  = 1'b0;
        occ_clr  = 1'b0;
        unique case (req_reg)
            REQ_FIND, REQ_ADD:
            begin
                res_ok   = found;
                res_slot = found ? SLOT_W'(free_idx) : '0;
                if ((req_reg == REQ_ADD) && found && (obj_reg != '0))
                begin
                    mem_we  = 1'b1;
                    occ_set = 1'b1;
                end
            end
            REQ_DELETE:
            begin
                res_ok   = hand_occ_reg;
                res_slot = hand_occ_reg ? hand_reg : '0;
                occ_clr  = hand_occ_reg;
            end
            REQ_GET:
            begin
                res_ok   = hand_occ_reg;
                res_slot = hand_occ_reg ? hand_reg : '0;
                res_obj  = hand_occ_reg ? rd_data_reg : '0;
            end
        endcase
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (exec_fire && occ_set)
        begin
            occ_next[free_idx[IDX_W-1:0]] = 1'b1;
        end
        if (exec_fire && occ_clr)
        begin
            occ_next[hand_reg[IDX_W-1:0]] = 1'b0;
        end
    end

    // reference ram
    always_ff @(posedge clk)
    begin
        if (exec_fire && mem_we)
        begin
            mem[free_idx[IDX_W-1:0]] <= obj_reg;
        end
        if (in_fire && in_range)
        begin
            rd_data_reg <= mem[slot_index[IDX_W-1:0]];
        end
    end

    // accept stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg      <= req_type;
            hand_reg     <= slot_index;
            obj_reg      <= object_ref;
            hand_occ_reg <= hand_occ;
            grp_any_reg  <= grp_any;
            grp_low_reg  <= grp_low;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            ok_reg      <= res_ok;
            slot_reg    <= res_slot;
            obj_out_reg <= res_obj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign slot_out   = slot_reg;
    assign object_out = obj_out_reg;

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter execute");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ok_reg || ((slot_reg == '0) && (obj_out_reg == '0))))
        else $error("failed result carries nonzero fields");

    a_occ_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(occ_reg))
        else $error("occupancy changed outside execute");

    a_occ_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> ($countones(occ_reg ^ $past(occ_reg)) <= 1))
        else $error("more than one slot changed per request");
`endif

endmodule
